### hdl/tmprof_pkg.sv
// ----------------------------------------------------------------------------
// tmprof_pkg: shared types and constants for the trapezoidal motion profile
// Item formats, controller/datapath command and status, phase and step codes,
// and the fixed-point helpers used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tmprof_pkg;

  localparam int POS_BITS = 24;   // encoder count width
  localparam int VAL_W    = 40;   // setpoint and profile value width
  localparam int MS_W     = 16;   // move and ramp time width
  localparam int TIME_W   = 18;   // elapsed time width
  localparam int WIN_W    = 10;   // near-goal window width
  localparam int OPB_W    = 18;   // width of the narrow arithmetic operand
  localparam int WIDE_W   = 64;   // working width of the arithmetic unit

  // Result phase codes
  localparam logic [2:0] PH_HOLD   = 3'd0;
  localparam logic [2:0] PH_NEAR   = 3'd1;
  localparam logic [2:0] PH_ACCEL  = 3'd2;
  localparam logic [2:0] PH_CRUISE = 3'd3;
  localparam logic [2:0] PH_DECEL  = 3'd4;
  localparam logic [2:0] PH_FINISH = 3'd5;

  // Datapath step codes
  localparam logic [2:0] SEL_PEAK  = 3'd0;
  localparam logic [2:0] SEL_ACCEL = 3'd1;
  localparam logic [2:0] SEL_REO   = 3'd2;
  localparam logic [2:0] SEL_CEO   = 3'd3;
  localparam logic [2:0] SEL_T1    = 3'd4;
  localparam logic [2:0] SEL_T2    = 3'd5;
  localparam logic [2:0] SEL_GOAL  = 3'd6;

  typedef struct packed {
    logic                       cmd;
    logic signed [POS_BITS-1:0] enc_count;
    logic signed [POS_BITS-1:0] goal_pos;
    logic [MS_W-1:0]            move_time;
    logic [MS_W-1:0]            ramp_time;
  } tmprof_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] setpoint;
    logic                    following;
    logic [2:0]              phase;
  } tmprof_out_t;

  typedef struct packed {
    logic       cap_move;
    logic       cap_tick;
    logic       go;
    logic       ld_res;
    logic       ld_out;
    logic [2:0] sel;
  } tmprof_cmd_t;

  typedef struct packed {
    logic       active;
    logic [2:0] phase;
    logic       den_zero;
    logic       ramp_zero;
    logic       done;
    logic       out_free;
  } tmprof_sts_t;

  // Clamp a wide value to the signed setpoint range
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-VAL_W:0] top;
    logic signed [VAL_W-1:0] r;
    top = v[WIDE_W-1:VAL_W-1];
    if ((&top) || !(|top)) begin
      r = v[VAL_W-1:0];
    end else if (v[WIDE_W-1]) begin
      r = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(VAL_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Halve, truncating toward zero
  function automatic logic signed [WIDE_W-1:0] half_tz(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] s;
    s = v + {{(WIDE_W-1){1'b0}}, v[WIDE_W-1]};
    return s >>> 1;
  endfunction

  // Sign-extend a profile value to the working width
  function automatic logic signed [WIDE_W-1:0] sx_val(input logic signed [VAL_W-1:0] v);
    return {{(WIDE_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

endpackage

`default_nettype wire

### hdl/tmprof_arith.sv
// ----------------------------------------------------------------------------
// tmprof_arith: iterative multiply / divide unit
// Signed wide operand times unsigned narrow operand by shift-add, one bit per
// cycle, or signed division truncating toward zero by restoring division.
// ----------------------------------------------------------------------------
`default_nettype none

module tmprof_arith
  import tmprof_pkg::*;
#(
  parameter int DIV_W = 41
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     go,
  input  wire logic                     is_div,
  input  wire logic signed [WIDE_W-1:0] a,
  input  wire logic [OPB_W-1:0]         b,
  output logic                          done,
  output logic signed [WIDE_W-1:0]      res
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic                     busy_r;
  logic                     div_r;
  logic                     neg_r;
  logic                     done_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [WIDE_W-1:0]        a_r;
  logic [OPB_W-1:0]         b_r;
  logic [WIDE_W-1:0]        acc_r;

  logic [OPB_W:0]           rem_sh;
  logic                     fits;
  logic [OPB_W:0]           rem_new;
  logic [WIDE_W-1:0]        mag;
  logic [WIDE_W-1:0]        quo;

  // One restoring division step
  always_comb begin
    rem_sh  = {acc_r[OPB_W-1:0], a_r[DIV_W-1]};
    fits    = rem_sh >= {1'b0, b_r};
    rem_new = fits ? (rem_sh - {1'b0, b_r}) : rem_sh;
    mag     = a[WIDE_W-1] ? (~a + 1'b1) : a;
    quo     = {{(WIDE_W-DIV_W){1'b0}}, a_r[DIV_W-1:0]};
  end

  // Advance one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        div_r  <= is_div;
        neg_r  <= a[WIDE_W-1];
        b_r    <= b;
        acc_r  <= '0;
        a_r    <= is_div ? mag : a;
        cnt_r  <= is_div ? CNT_W'(DIV_W) : CNT_W'(OPB_W);
      end else if (busy_r) begin
        if (div_r) begin
          acc_r <= {{(WIDE_W-OPB_W){1'b0}}, rem_new[OPB_W-1:0]};
          a_r   <= {a_r[WIDE_W-2:0], fits};
        end else begin
          if (b_r[0]) begin
            acc_r <= acc_r + a_r;
          end
          a_r <= {a_r[WIDE_W-2:0], 1'b0};
          b_r <= {1'b0, b_r[OPB_W-1:1]};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = div_r ? (neg_r ? -signed'(quo) : signed'(quo)) : signed'(acc_r);

endmodule

`default_nettype wire

### hdl/tmprof_dp.sv
// ----------------------------------------------------------------------------
// tmprof_dp: profile datapath
// Holds the move state, evaluates ticks, drives the arithmetic unit and keeps
// the result register with its valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tmprof_dp
  import tmprof_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int DIV_W     = 41
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tmprof_in_t        in_data,
  input  wire logic              cfg_we,
  input  wire logic [WIN_W-1:0]  cfg_data,
  input  wire tmprof_cmd_t       cmd,
  output tmprof_sts_t            st,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tmprof_out_t            out_data
);

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  logic [WIN_W-1:0]           win_r;
  logic signed [POS_BITS-1:0] last_r;
  logic signed [POS_BITS-1:0] start_r;
  logic signed [POS_BITS-1:0] target_r;
  logic [MS_W-1:0]            ramp_r;
  logic [MS_W-1:0]            cruise_r;
  logic signed [VAL_W-1:0]    peak_r;
  logic signed [VAL_W-1:0]    accel_r;
  logic signed [VAL_W-1:0]    reo_r;
  logic signed [VAL_W-1:0]    ceo_r;
  logic [TIME_W-1:0]          elapsed_r;
  logic                       active_r;
  logic signed [VAL_W-1:0]    held_r;
  logic [2:0]                 phase_r;
  logic signed [WIDE_W-1:0]   tmp_r;
  logic                       out_valid_r;
  tmprof_out_t                out_data_r;

  logic signed [POS_BITS:0]   diff;
  logic [POS_BITS:0]          adiff;
  logic                       near;
  logic                       act_tick;
  logic [TIME_W-1:0]          el_inc;
  logic [TIME_W:0]            t_ext;
  logic [TIME_W:0]            e1;
  logic [TIME_W:0]            e2;
  logic [TIME_W:0]            e3;
  logic [2:0]                 tick_phase;
  logic [MS_W:0]              two_rt;
  logic [MS_W-1:0]            cruise_mv;
  logic [MS_W:0]              den;
  logic signed [WIDE_W-1:0]   start_fx;
  logic signed [WIDE_W-1:0]   goal_fx;
  logic [TIME_W-1:0]          tb;
  logic signed [WIDE_W-1:0]   op_a;
  logic [OPB_W-1:0]           op_b;
  logic                       is_div;
  logic                       ar_done;
  logic signed [WIDE_W-1:0]   ar_res;
  logic signed [WIDE_W-1:0]   off;

  // Evaluate a tick item against the stored move
  always_comb begin
    diff     = {in_data.enc_count[POS_BITS-1], in_data.enc_count}
             - {target_r[POS_BITS-1], target_r};
    adiff    = diff[POS_BITS] ? (~diff + 1'b1) : diff;
    near     = adiff <= {{(POS_BITS+1-WIN_W){1'b0}}, win_r};
    act_tick = active_r && (in_data.enc_count != target_r);
    el_inc   = (elapsed_r == TIME_MAX) ? elapsed_r : elapsed_r + 1'b1;
    t_ext    = {1'b0, el_inc};
    e1       = {{(TIME_W+1-MS_W){1'b0}}, ramp_r};
    e2       = e1 + {{(TIME_W+1-MS_W){1'b0}}, cruise_r};
    e3       = e2 + e1;
    priority if (!act_tick) begin
      tick_phase = PH_HOLD;
    end else if (near) begin
      tick_phase = PH_NEAR;
    end else if (e1 >= t_ext) begin
      tick_phase = PH_ACCEL;
    end else if (e2 >= t_ext) begin
      tick_phase = PH_CRUISE;
    end else if (e3 >= t_ext) begin
      tick_phase = PH_DECEL;
    end else begin
      tick_phase = PH_FINISH;
    end
  end

  // Move setup terms
  always_comb begin
    two_rt    = {in_data.ramp_time, 1'b0};
    cruise_mv = ({1'b0, in_data.move_time} > two_rt)
              ? (in_data.move_time - two_rt[MS_W-1:0]) : '0;
    den       = {1'b0, ramp_r} + {1'b0, cruise_r};
    start_fx  = {{(WIDE_W-POS_BITS){start_r[POS_BITS-1]}}, start_r} <<< FRAC_BITS;
    goal_fx   = {{(WIDE_W-POS_BITS){target_r[POS_BITS-1]}}, target_r} <<< FRAC_BITS;
  end

  // Select arithmetic operands for the current step
  always_comb begin
    unique case (phase_r)
      PH_CRUISE: tb = elapsed_r - {{(TIME_W-MS_W){1'b0}}, ramp_r};
      PH_DECEL:  tb = elapsed_r - {{(TIME_W-MS_W){1'b0}}, ramp_r}
                    - {{(TIME_W-MS_W){1'b0}}, cruise_r};
      default:   tb = elapsed_r;
    endcase
    is_div = (cmd.sel == SEL_PEAK) || (cmd.sel == SEL_ACCEL);
    unique case (cmd.sel)
      SEL_PEAK: begin
        op_a = goal_fx - start_fx;
        op_b = {{(OPB_W-MS_W-1){1'b0}}, den};
      end
      SEL_ACCEL, SEL_REO: begin
        op_a = sx_val(peak_r);
        op_b = {{(OPB_W-MS_W){1'b0}}, ramp_r};
      end
      SEL_CEO: begin
        op_a = sx_val(peak_r);
        op_b = {{(OPB_W-MS_W){1'b0}}, cruise_r};
      end
      SEL_T1: begin
        op_a = sx_val(accel_r);
        op_b = tb;
      end
      SEL_T2: begin
        op_a = (phase_r == PH_CRUISE) ? sx_val(peak_r) : tmp_r;
        op_b = tb;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    unique case (phase_r)
      PH_ACCEL:  off = half_tz(ar_res);
      PH_CRUISE: off = sx_val(reo_r) + ar_res;
      default:   off = sx_val(ceo_r) + ar_res;
    endcase
  end

  tmprof_arith #(
    .DIV_W (DIV_W)
  ) u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (cmd.go),
    .is_div (is_div),
    .a      (op_a),
    .b      (op_b),
    .done   (ar_done),
    .res    (ar_res)
  );

  // Update profile state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= WIN_W'(10);
      last_r    <= '0;
      start_r   <= '0;
      target_r  <= '0;
      ramp_r    <= '0;
      cruise_r  <= '0;
      peak_r    <= '0;
      accel_r   <= '0;
      reo_r     <= '0;
      ceo_r     <= '0;
      elapsed_r <= '0;
      active_r  <= 1'b0;
      held_r    <= '0;
      phase_r   <= PH_HOLD;
      tmp_r     <= '0;
    end else begin
      if (cfg_we) begin
        win_r <= cfg_data;
      end
      if (cmd.cap_move) begin
        target_r  <= in_data.goal_pos;
        start_r   <= last_r;
        ramp_r    <= in_data.ramp_time;
        cruise_r  <= cruise_mv;
        peak_r    <= '0;
        accel_r   <= '0;
        reo_r     <= '0;
        ceo_r     <= '0;
        elapsed_r <= '0;
        active_r  <= 1'b1;
        phase_r   <= PH_HOLD;
      end
      if (cmd.cap_tick) begin
        last_r   <= in_data.enc_count;
        active_r <= act_tick;
        phase_r  <= tick_phase;
        if (act_tick) begin
          elapsed_r <= el_inc;
        end
      end
      if (cmd.ld_res) begin
        unique case (cmd.sel)
          SEL_PEAK:  peak_r  <= sat_val(ar_res);
          SEL_ACCEL: accel_r <= ar_res[VAL_W-1:0];
          SEL_REO:   reo_r   <= sat_val(half_tz(ar_res));
          SEL_CEO:   ceo_r   <= sat_val(sx_val(reo_r) + ar_res);
          SEL_T1:    tmp_r   <= (phase_r == PH_ACCEL) ? ar_res
                              : sx_val(peak_r) - half_tz(ar_res);
          SEL_T2:    held_r  <= sat_val(start_fx + off);
          SEL_GOAL:  held_r  <= sat_val(goal_fx);
          default:   tmp_r   <= tmp_r;
        endcase
      end
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_data_r.setpoint  <= held_r;
      out_data_r.following <= active_r;
      out_data_r.phase     <= phase_r;
    end
  end

  always_comb begin
    st.active    = active_r;
    st.phase     = phase_r;
    st.den_zero  = (den == '0);
    st.ramp_zero = (ramp_r == '0);
    st.done      = ar_done;
    st.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### hdl/tmprof_ctrl.sv
// ----------------------------------------------------------------------------
// tmprof_ctrl: profile controller
// Accepts one item at a time, steps the datapath through the divisions and
// multiplications that a move or a tick needs, then issues the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tmprof_ctrl
  import tmprof_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_cmd,
  output logic             in_ready,
  input  wire tmprof_sts_t st,
  output tmprof_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOVE  = 3'd1;
  localparam logic [2:0] S_TICK  = 3'd2;
  localparam logic [2:0] S_ISSUE = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [2:0] sel_r;
  logic [2:0] sel_nxt;

  // Sequence the steps of one item
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.sel   = sel_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_move = !in_cmd;
          cmd.cap_tick = in_cmd;
          state_nxt    = in_cmd ? S_TICK : S_MOVE;
        end
      end
      S_MOVE: begin
        if (st.den_zero) begin
          state_nxt = S_FIN;
        end else begin
          sel_nxt   = SEL_PEAK;
          state_nxt = S_ISSUE;
        end
      end
      S_TICK: begin
        priority if (!st.active) begin
          state_nxt = S_FIN;
        end else if ((st.phase == PH_NEAR) || (st.phase == PH_FINISH)) begin
          cmd.sel    = SEL_GOAL;
          cmd.ld_res = 1'b1;
          state_nxt  = S_FIN;
        end else if (st.phase == PH_CRUISE) begin
          sel_nxt   = SEL_T2;
          state_nxt = S_ISSUE;
        end else begin
          sel_nxt   = SEL_T1;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.go    = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (st.done) begin
          cmd.ld_res = 1'b1;
          state_nxt  = S_ISSUE;
          unique case (sel_r)
            SEL_PEAK:  sel_nxt = st.ramp_zero ? SEL_REO : SEL_ACCEL;
            SEL_ACCEL: sel_nxt = SEL_REO;
            SEL_REO:   sel_nxt = SEL_CEO;
            SEL_T1:    sel_nxt = SEL_T2;
            default:   state_nxt = S_FIN;
          endcase
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= SEL_PEAK;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/trapezoidal_motion_profile_top.sv
// A cruise tick makes one 18-step shift-add pass and a ramp tick two; other
// ticks need no arithmetic. A move with nonzero ramp plus cruise time runs a
// 41-step division for the peak, one for the acceleration if the ramp time
// is nonzero, and two 18-step multiplies. One item is in work at a time; the
// next is taken while the previous result waits in the output register.
// Reset (synchronous, rst_n low) clears all profile state; the window is 10.
// ----------------------------------------------------------------------------
// trapezoidal_motion_profile_top: trapezoidal position setpoint generator
// Move beats set up a trapezoidal profile; tick beats return the setpoint.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoidal_motion_profile_top
  import tmprof_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire tmprof_in_t       in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tmprof_out_t           out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [WIN_W-1:0] cfg_data
);

  localparam int DIV_W = (POS_BITS + FRAC_BITS + 1 > VAL_W)
                       ? (POS_BITS + FRAC_BITS + 1) : VAL_W;

  tmprof_cmd_t cmd;
  tmprof_sts_t st;

  assign cfg_ready = 1'b1;

  tmprof_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tmprof_dp #(
    .FRAC_BITS (FRAC_BITS),
    .DIV_W     (DIV_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat taken while an item is in work");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.following) |-> (out_data.phase == PH_HOLD))
    else $error("profile phase reported while not following");
`endif

endmodule

`default_nettype wire
